[rtl/tass_pkg.sv]
// Shared types, constants and helper functions for the tensor axis swap scatter block.
package tass_pkg;

   localparam int DIM_BITS   = 12;
   localparam int ADDR_BITS  = 24;
   localparam int SIZE_W     = 13;
   localparam int MODE_W     = 2;
   localparam int VALUE_W    = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = SIZE_W;

   localparam int EFF_W  = DIM_BITS + 1;
   localparam int PAIR_W = 2 * EFF_W;
   localparam int SAT_W  = ADDR_BITS + 1;
   localparam int CMP_W  = PAIR_W + SAT_W;
   localparam int PROD_W = 2 * SAT_W;

   localparam logic [CMP_W-1:0]  SAT_MAX = (CMP_W'(1) << ADDR_BITS) + CMP_W'(1);
   localparam logic [PROD_W-1:0] ADDR_LIMIT = PROD_W'(1) << ADDR_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_AXIS1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_AXIS2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_AXIS3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_AXIS4 = 3'd4;

   localparam logic [MODE_W-1:0] MODE_SWAP_12 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SWAP_13 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SWAP_23 = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] elem_value;
      logic               restart;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] dest_address;
      logic [VALUE_W-1:0]   out_value;
      logic                 tensor_last;
      logic                 size_error;
   } rsp_payload_type;

   // effective (clamped) sizes and mode
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [EFF_W-1:0]  s1;
      logic [EFF_W-1:0]  s2;
      logic [EFF_W-1:0]  s3;
      logic [EFF_W-1:0]  s4;
   } cfg_type;

   // source coordinates of one word
   typedef struct packed {
      logic [DIM_BITS-1:0] a1;
      logic [DIM_BITS-1:0] a2;
      logic [DIM_BITS-1:0] a3;
      logic [DIM_BITS-1:0] a4;
      logic                last;
   } coord_type;

   function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      if (s == '0) begin
         return EFF_W'(1);
      end else if (int'(s) > (1 << DIM_BITS)) begin
         return EFF_W'(1 << DIM_BITS);
      end else begin
         return EFF_W'(s);
      end
   endfunction

   // saturate a pair product just above the address range
   function automatic logic [SAT_W-1:0] sat_pair(input logic [PAIR_W-1:0] x);
      if (CMP_W'(x) > SAT_MAX) begin
         return SAT_W'(SAT_MAX);
      end else begin
         return SAT_W'(x);
      end
   endfunction

endpackage

[rtl/tass_cfg.sv]
// Configuration registers with size clamping.
module tass_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [tass_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tass_pkg::CSR_DATA_W-1:0]  csr_data,
   output tass_pkg::cfg_type                cfg
);

   logic [tass_pkg::MODE_W-1:0] mode_ff;
   logic [tass_pkg::SIZE_W-1:0] size1_ff;
   logic [tass_pkg::SIZE_W-1:0] size2_ff;
   logic [tass_pkg::SIZE_W-1:0] size3_ff;
   logic [tass_pkg::SIZE_W-1:0] size4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tass_pkg::MODE_SWAP_12;
         size1_ff <= tass_pkg::SIZE_W'(1);
         size2_ff <= tass_pkg::SIZE_W'(1);
         size3_ff <= tass_pkg::SIZE_W'(1);
         size4_ff <= tass_pkg::SIZE_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tass_pkg::CSR_SWAP_MODE:  mode_ff  <= csr_data[tass_pkg::MODE_W-1:0];
            tass_pkg::CSR_SIZE_AXIS1: size1_ff <= csr_data[tass_pkg::SIZE_W-1:0];
            tass_pkg::CSR_SIZE_AXIS2: size2_ff <= csr_data[tass_pkg::SIZE_W-1:0];
            tass_pkg::CSR_SIZE_AXIS3: size3_ff <= csr_data[tass_pkg::SIZE_W-1:0];
            tass_pkg::CSR_SIZE_AXIS4: size4_ff <= csr_data[tass_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.mode = mode_ff;
   assign cfg.s1   = tass_pkg::eff_size(size1_ff);
   assign cfg.s2   = tass_pkg::eff_size(size2_ff);
   assign cfg.s3   = tass_pkg::eff_size(size3_ff);
   assign cfg.s4   = tass_pkg::eff_size(size4_ff);

endmodule

[rtl/tass_counter.sv]
// Mixed-radix source position counters with restart and last-element detection.
module tass_counter (
   input  logic                clock,
   input  logic                reset,
   input  tass_pkg::cfg_type   cfg,
   input  logic                accept,
   input  logic                restart,
   output tass_pkg::coord_type coord
);

   logic [tass_pkg::DIM_BITS-1:0] pos1_ff, pos2_ff, pos3_ff, pos4_ff;
   logic [tass_pkg::DIM_BITS-1:0] cur1, cur2, cur3, cur4;
   logic                          top1, top2, top3, top4;

   assign cur1 = restart ? '0 : pos1_ff;
   assign cur2 = restart ? '0 : pos2_ff;
   assign cur3 = restart ? '0 : pos3_ff;
   assign cur4 = restart ? '0 : pos4_ff;

   // at or beyond the last position of its axis
   assign top1 = ({1'b0, cur1} + tass_pkg::EFF_W'(1)) >= cfg.s1;
   assign top2 = ({1'b0, cur2} + tass_pkg::EFF_W'(1)) >= cfg.s2;
   assign top3 = ({1'b0, cur3} + tass_pkg::EFF_W'(1)) >= cfg.s3;
   assign top4 = ({1'b0, cur4} + tass_pkg::EFF_W'(1)) >= cfg.s4;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos1_ff <= '0;
         pos2_ff <= '0;
         pos3_ff <= '0;
         pos4_ff <= '0;
      end else if (accept) begin
         pos1_ff <= top1 ? '0 : cur1 + 1'b1;
         pos2_ff <= !top1 ? cur2 : (top2 ? '0 : cur2 + 1'b1);
         pos3_ff <= !(top1 && top2) ? cur3 : (top3 ? '0 : cur3 + 1'b1);
         pos4_ff <= !(top1 && top2 && top3) ? cur4 : (top4 ? '0 : cur4 + 1'b1);
      end
   end

   assign coord.a1   = cur1;
   assign coord.a2   = cur2;
   assign coord.a3   = cur3;
   assign coord.a4   = cur4;
   assign coord.last = top1 && top2 && top3 && top4;

endmodule

[rtl/tass_addr_pipe.sv]
// Destination address pipeline: stride products, size check and output register.
module tass_addr_pipe (
   input  logic                             clock,
   input  logic                             reset,
   input  tass_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   input  logic [tass_pkg::VALUE_W-1:0]     in_value,
   input  tass_pkg::coord_type              in_coord,
   output logic                             advance,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tass_pkg::rsp_payload_type        rsp_payload
);

   localparam int AW = tass_pkg::ADDR_BITS;
   localparam int DW = tass_pkg::DIM_BITS;

   typedef struct packed {
      logic [tass_pkg::VALUE_W-1:0] value;
      tass_pkg::coord_type          coord;
   } st1_type;

   typedef struct packed {
      logic [tass_pkg::VALUE_W-1:0] value;
      logic                         last;
      logic [DW-1:0]                a_term;
      logic [AW-1:0]                b_term;
      logic [DW-1:0]                c_idx;
      logic [tass_pkg::PAIR_W-1:0]  c_stride;
      logic [DW-1:0]                a4;
      logic [tass_pkg::PAIR_W-1:0]  s12;
      logic [tass_pkg::PAIR_W-1:0]  s34;
   } st2_type;

   typedef struct packed {
      logic [tass_pkg::VALUE_W-1:0] value;
      logic                         last;
      logic                         err;
      logic [AW-1:0]                ab;
      logic [AW-1:0]                c_term;
      logic [AW-1:0]                p3;
      logic [DW-1:0]                a4;
   } st3_type;

   typedef struct packed {
      logic [tass_pkg::VALUE_W-1:0] value;
      logic                         last;
      logic                         err;
      logic [AW-1:0]                abc;
      logic [AW-1:0]                d_term;
   } st4_type;

   logic [3:0] v_ff;
   logic       out_valid_ff;
   st1_type    st1_ff, st1_in;
   st2_type    st2_ff, st2_in;
   st3_type    st3_ff, st3_in;
   st4_type    st4_ff, st4_in;
   tass_pkg::rsp_payload_type out_ff, out_in;

   logic [tass_pkg::EFF_W-1:0]          b_stride;
   logic [DW-1:0]                       b_idx;
   logic [tass_pkg::EFF_W+DW-1:0]       b_prod;
   logic [tass_pkg::PAIR_W-1:0]         s12, s13, s23, s34;
   logic [tass_pkg::PAIR_W+DW-1:0]      c_prod;
   logic [tass_pkg::PAIR_W+tass_pkg::EFF_W-1:0] p3_prod;
   logic [tass_pkg::SAT_W-1:0]          sat12, sat34;
   logic [tass_pkg::PROD_W-1:0]         err_prod;
   logic [AW+DW-1:0]                    d_prod;

   assign advance = !reset && (!out_valid_ff || rsp_ready);

   // stage 1: coordinates as captured
   always_comb begin
      st1_in.value = in_value;
      st1_in.coord = in_coord;
   end

   // stage 2: pair products and the single-stride term
   assign s12 = cfg.s1 * cfg.s2;
   assign s13 = cfg.s1 * cfg.s3;
   assign s23 = cfg.s2 * cfg.s3;
   assign s34 = cfg.s3 * cfg.s4;

   always_comb begin
      st2_in.value    = st1_ff.value;
      st2_in.last     = st1_ff.coord.last;
      st2_in.a4       = st1_ff.coord.a4;
      st2_in.s12      = s12;
      st2_in.s34      = s34;
      unique case (cfg.mode)
         tass_pkg::MODE_SWAP_12: begin
            st2_in.a_term   = st1_ff.coord.a2;
            b_stride        = cfg.s2;
            b_idx           = st1_ff.coord.a1;
            st2_in.c_idx    = st1_ff.coord.a3;
            st2_in.c_stride = s12;
         end
         tass_pkg::MODE_SWAP_13: begin
            st2_in.a_term   = st1_ff.coord.a3;
            b_stride        = cfg.s3;
            b_idx           = st1_ff.coord.a2;
            st2_in.c_idx    = st1_ff.coord.a1;
            st2_in.c_stride = s23;
         end
         tass_pkg::MODE_SWAP_23: begin
            st2_in.a_term   = st1_ff.coord.a1;
            b_stride        = cfg.s1;
            b_idx           = st1_ff.coord.a3;
            st2_in.c_idx    = st1_ff.coord.a2;
            st2_in.c_stride = s13;
         end
         default: begin
            st2_in.a_term   = st1_ff.coord.a1;
            b_stride        = cfg.s1;
            b_idx           = st1_ff.coord.a2;
            st2_in.c_idx    = st1_ff.coord.a3;
            st2_in.c_stride = s12;
         end
      endcase
      b_prod        = b_stride * b_idx;
      st2_in.b_term = AW'(b_prod);
   end

   // stage 3: double-stride term, tensor stride and size check
   always_comb begin
      c_prod   = st2_ff.c_stride * st2_ff.c_idx;
      p3_prod  = st2_ff.s12 * cfg.s3;
      sat12    = tass_pkg::sat_pair(st2_ff.s12);
      sat34    = tass_pkg::sat_pair(st2_ff.s34);
      err_prod = sat12 * sat34;
      st3_in.value  = st2_ff.value;
      st3_in.last   = st2_ff.last;
      st3_in.err    = err_prod > tass_pkg::ADDR_LIMIT;
      st3_in.ab     = AW'(st2_ff.a_term) + st2_ff.b_term;
      st3_in.c_term = AW'(c_prod);
      st3_in.p3     = AW'(p3_prod);
      st3_in.a4     = st2_ff.a4;
   end

   // stage 4: slowest-axis term
   always_comb begin
      d_prod        = st3_ff.p3 * st3_ff.a4;
      st4_in.value  = st3_ff.value;
      st4_in.last   = st3_ff.last;
      st4_in.err    = st3_ff.err;
      st4_in.abc    = st3_ff.ab + st3_ff.c_term;
      st4_in.d_term = AW'(d_prod);
   end

   always_comb begin
      out_in.dest_address = st4_ff.abc + st4_ff.d_term;
      out_in.out_value    = st4_ff.value;
      out_in.tensor_last  = st4_ff.last;
      out_in.size_error   = st4_ff.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v_ff         <= {v_ff[2:0], in_valid};
         out_valid_ff <= v_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

[rtl/tensor_axis_swap_scatter.sv]
// Top level: axis-swapping scatter address generator for column-major tensors.
// Takes one source element word per cycle, in source order (axis 1 fastest), and
// returns one word per element with its destination address in the tensor with
// two axes swapped, the element bits unchanged, a last-element flag and a size
// error flag. Throughput is one word per clock while the output is not held; a word
// reaches rsp_valid through the input register, three stride multiplier stages
// and the output register. A result held by rsp_ready low freezes the whole
// pipeline and drops req_ready, so up to five words wait inside; req_ready is
// also low during reset. The position counters step on acceptance, so the
// address stream carries no gaps between tensors. The user must write registers only
// while no word is in flight; the block itself does not enforce this.
module tensor_axis_swap_scatter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tass_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tass_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [tass_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tass_pkg::CSR_DATA_W-1:0]  csr_data
);

   tass_pkg::cfg_type   cfg;
   tass_pkg::coord_type coord;
   logic                accept;

   assign accept = req_valid && req_ready;

   tass_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   tass_counter u_counter (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .restart (req_payload.restart),
      .coord   (coord)
   );

   tass_addr_pipe u_addr_pipe (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (accept),
      .in_value    (req_payload.elem_value),
      .in_coord    (coord),
      .advance     (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[bench/tb_top.sv]
// Testbench for the tensor axis swap scatter block: random and directed words against a predictor.
`timescale 1ns / 100ps

module tb_top;
   import tass_pkg::*;

   localparam int      WATCHDOG_LIMIT = 3000;
   localparam int      DRAIN_CYCLES   = 10;
   localparam int      LONG_HOLD      = 300;
   localparam int      PRINT_LIMIT    = 200;
   localparam longint unsigned ADDR_SPAN = 64'd1 << ADDR_BITS;
   localparam logic [MODE_W-1:0] MODE_LIST [4] =
      '{MODE_SWAP_12, MODE_SWAP_13, MODE_SWAP_23, MODE_NONE};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   tensor_axis_swap_scatter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [MODE_W-1:0]   cfg_mode = MODE_SWAP_12;
   logic [SIZE_W-1:0]   cfg_extent1 = SIZE_W'(1);
   logic [SIZE_W-1:0]   cfg_extent2 = SIZE_W'(1);
   logic [SIZE_W-1:0]   cfg_extent3 = SIZE_W'(1);
   logic [SIZE_W-1:0]   cfg_extent4 = SIZE_W'(1);
   logic [DIM_BITS-1:0] pos_i1 = '0;
   logic [DIM_BITS-1:0] pos_i2 = '0;
   logic [DIM_BITS-1:0] pos_i3 = '0;
   logic [DIM_BITS-1:0] pos_i4 = '0;

   req_payload_type elem_queue [$];
   rsp_payload_type scatter_expected [$];

   int  push_count = 0;
   int  rsp_count = 0;
   int  fail_count = 0;
   int  print_count = 0;
   int  send_idle_pct = 0;
   int  rsp_idle_pct = 0;
   bit  quiet = 1'b0;
   bit  long_hold_done = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;
   logic req_taken = 1'b0;

   function automatic longint unsigned clamp_extent(input logic [SIZE_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end else if (raw > (SIZE_W'(1) << DIM_BITS)) begin
         return longint'(1) << DIM_BITS;
      end else begin
         return raw;
      end
   endfunction

   function automatic rsp_payload_type predict_scatter(input req_payload_type word);
      rsp_payload_type res;
      longint unsigned e1, e2, e3, e4, vol3, addr, a1, a2, a3, a4;
      e1 = clamp_extent(cfg_extent1);
      e2 = clamp_extent(cfg_extent2);
      e3 = clamp_extent(cfg_extent3);
      e4 = clamp_extent(cfg_extent4);
      vol3 = e1 * e2 * e3;
      if (word.restart) begin
         pos_i1 = '0;
         pos_i2 = '0;
         pos_i3 = '0;
         pos_i4 = '0;
      end
      a1 = pos_i1;
      a2 = pos_i2;
      a3 = pos_i3;
      a4 = pos_i4;
      case (cfg_mode)
         MODE_SWAP_12: addr = a2 + e2 * a1 + e1 * e2 * a3 + vol3 * a4;
         MODE_SWAP_13: addr = a3 + e3 * a2 + e3 * e2 * a1 + vol3 * a4;
         MODE_SWAP_23: addr = a1 + e1 * a3 + e1 * e3 * a2 + vol3 * a4;
         default:      addr = a1 + e1 * a2 + e1 * e2 * a3 + vol3 * a4;
      endcase
      res.dest_address = addr[ADDR_BITS-1:0];
      res.out_value    = word.elem_value;
      res.tensor_last  = (a1 + 1 >= e1) && (a2 + 1 >= e2) && (a3 + 1 >= e3) && (a4 + 1 >= e4);
      res.size_error   = vol3 > (ADDR_SPAN / e4);
      // odometer step; a counter past its extent wraps
      if (a1 + 1 < e1) begin
         pos_i1 = pos_i1 + 1'b1;
      end else begin
         pos_i1 = '0;
         if (a2 + 1 < e2) begin
            pos_i2 = pos_i2 + 1'b1;
         end else begin
            pos_i2 = '0;
            if (a3 + 1 < e3) begin
               pos_i3 = pos_i3 + 1'b1;
            end else begin
               pos_i3 = '0;
               if (a4 + 1 < e4) begin
                  pos_i4 = pos_i4 + 1'b1;
               end else begin
                  pos_i4 = '0;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      fail_count++;
      if (print_count < PRINT_LIMIT) begin
         print_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // sender
   always @(negedge clock) begin : drive_req
      logic            next_valid;
      req_payload_type next_word;
      next_valid = req_valid;
      next_word  = req_payload;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (send_gap != 0) begin
            send_gap--;
         end else if (elem_queue.size() != 0) begin
            if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(0, 13);
            end else begin
               next_word  = elem_queue.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid   <= next_valid;
      req_payload <= next_word;
   end

   // receiver
   always @(negedge clock) begin : drive_rsp
      logic next_ready;
      next_ready = 1'b1;
      if (reset) begin
         next_ready = 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (!long_hold_done && elem_queue.size() > 100) begin
         long_hold_done = 1'b1;
         hold_left  = LONG_HOLD - 1;
         next_ready = 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rsp_idle_pct) begin
         stall_left = $urandom_range(0, 13);
         next_ready = 1'b0;
      end
      rsp_ready <= next_ready;
   end

   // prediction on acceptance, checking on delivery
   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            scatter_expected.push_back(predict_scatter(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (scatter_expected.size() == 0) begin
               fail_count++;
               if (print_count < PRINT_LIMIT) begin
                  print_count++;
                  $display("%0t: unexpected word, expected none, actual %h", $time, rsp_payload);
               end
            end else begin
               want = scatter_expected.pop_front();
               if (rsp_payload.dest_address !== want.dest_address)
                  report_field("dest_address", want.dest_address, rsp_payload.dest_address);
               if (rsp_payload.out_value !== want.out_value)
                  report_field("out_value", want.out_value, rsp_payload.out_value);
               if (rsp_payload.tensor_last !== want.tensor_last)
                  report_field("tensor_last", want.tensor_last, rsp_payload.tensor_last);
               if (rsp_payload.size_error !== want.size_error)
                  report_field("size_error", want.size_error, rsp_payload.size_error);
            end
         end
      end
      req_taken <= !reset && req_valid && req_ready;
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      case (idx)
         CSR_SWAP_MODE:  cfg_mode    = data[MODE_W-1:0];
         CSR_SIZE_AXIS1: cfg_extent1 = data;
         CSR_SIZE_AXIS2: cfg_extent2 = data;
         CSR_SIZE_AXIS3: cfg_extent3 = data;
         CSR_SIZE_AXIS4: cfg_extent4 = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic program_shape(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] x1,
                                input logic [SIZE_W-1:0] x2, input logic [SIZE_W-1:0] x3,
                                input logic [SIZE_W-1:0] x4);
      write_reg(CSR_SWAP_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_SIZE_AXIS1, x1);
      write_reg(CSR_SIZE_AXIS2, x2);
      write_reg(CSR_SIZE_AXIS3, x3);
      write_reg(CSR_SIZE_AXIS4, x4);
   endtask

   task automatic push_elem(input logic [VALUE_W-1:0] value, input logic restart);
      req_payload_type word;
      word.elem_value = value;
      word.restart    = restart;
      elem_queue.push_back(word);
      push_count++;
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_tensor_run(input int count, input bit restart_first);
      for (int k = 0; k < count; k++) begin
         push_elem(rand_value(), (k == 0 && restart_first) || $urandom_range(0, 49) == 0);
      end
   endtask

   function automatic logic [SIZE_W-1:0] rand_extent();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return SIZE_W'(1) << DIM_BITS;
         2:       return SIZE_W'($urandom_range(4097, 8191));
         3:       return SIZE_W'($urandom);
         4, 5:    return SIZE_W'($urandom_range(5, 16));
         default: return SIZE_W'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic wait_drained();
      while (rsp_count != push_count) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int               count;
      longint unsigned  volume;
      logic [SIZE_W-1:0] x1, x2, x3, x4;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset shape: every word is the whole tensor
      push_elem('0, 1'b1);
      push_elem('1, 1'b0);
      push_elem(rand_value(), 1'b0);
      wait_drained();
      // no swap, zero size read as one
      program_shape(MODE_NONE, '0, SIZE_W'(2), SIZE_W'(2), SIZE_W'(2));
      push_tensor_run(8, 1'b1);
      wait_drained();
      // oversize axes clamp, product past the address range
      program_shape(MODE_SWAP_23, '1, SIZE_W'(4097), SIZE_W'(3), SIZE_W'(1));
      push_tensor_run(4, 1'b1);
      wait_drained();
      // shrink mid-tensor: counters left beyond their extents
      program_shape(MODE_SWAP_13, SIZE_W'(2), SIZE_W'(3), SIZE_W'(1), SIZE_W'(1));
      for (int k = 0; k < 6; k++) push_elem(rand_value(), 1'b0);
      wait_drained();
      // product exactly at the address range
      program_shape(MODE_SWAP_12, SIZE_W'(4096), SIZE_W'(4096), SIZE_W'(1), SIZE_W'(1));
      push_tensor_run(2, 1'b1);
      wait_drained();

      for (int phase = 0; push_count < 1240; phase++) begin
         send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         rsp_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         if (phase == 0) begin
            x1 = SIZE_W'($urandom_range(1, 4));
            x2 = SIZE_W'($urandom_range(1, 4));
            x3 = SIZE_W'($urandom_range(1, 4));
            x4 = SIZE_W'($urandom_range(1, 4));
         end else begin
            x1 = rand_extent();
            x2 = rand_extent();
            x3 = rand_extent();
            x4 = rand_extent();
         end
         program_shape(MODE_LIST[$urandom_range(0, 3)], x1, x2, x3, x4);
         volume = clamp_extent(x1) * clamp_extent(x2) * clamp_extent(x3) * clamp_extent(x4);
         if (phase == 0) begin
            count = 260;
         end else if (volume <= 128) begin
            count = int'(volume) * $urandom_range(1, 3) + $urandom_range(0, int'(volume) - 1);
         end else begin
            count = $urandom_range(8, 40);
         end
         if (count > 300) count = 300;
         push_tensor_run(count, $urandom_range(0, 3) != 0);
         wait_drained();
      end

      // closing stretch at full rate
      quiet = 1'b1;
      program_shape(MODE_LIST[$urandom_range(0, 3)], SIZE_W'($urandom_range(1, 4)),
                    SIZE_W'($urandom_range(1, 4)), SIZE_W'($urandom_range(1, 4)),
                    SIZE_W'($urandom_range(1, 2)));
      push_tensor_run(60, 1'b1);
      wait_drained();

      if (fail_count == 0 && scatter_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (scatter_expected.size() != 0)
            $display("%0t: %0d words never arrived", $time, scatter_expected.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tass_pkg.sv
rtl/tass_cfg.sv
rtl/tass_counter.sv
rtl/tass_addr_pipe.sv
rtl/tensor_axis_swap_scatter.sv
bench/tb_top.sv
